/* rtl/core/wtr_pkg.sv */
// ---------------------------------------------------------------------------
// wtr_pkg
// Shared constants and types of the F(2x2,3x3) input tile transform.
// ---------------------------------------------------------------------------
package wtr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LANES       = 4;
  localparam int TILE_DIM    = 2 + 3 - 1;
  localparam int TILE_SIZE   = TILE_DIM * TILE_DIM;
  localparam int IDX_BITS    = $clog2(TILE_SIZE);
  localparam int DIM_BITS    = $clog2(TILE_DIM);
  // column pass adds one bit, row pass one more, output keeps one spare
  localparam int T_BITS      = SAMPLE_BITS + 1;
  localparam int COEF_BITS   = SAMPLE_BITS + 3;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TILE_SIZE - 1);

  typedef logic [IDX_BITS-1:0] idx_t;

  // per-cycle commands from the controller to every lane
  typedef struct packed {
    logic shift_in;   // element beat: shift it into the tile store
    logic t_load;     // sixteenth element: load the column-pass register
    logic r_load;     // move column pass through the row pass into the output line
    logic r_shift;    // output beat: advance the output line
  } wtr_ctl_t;

endpackage

/* rtl/core/wtr_in_if.sv */
// ---------------------------------------------------------------------------
// wtr_in_if
// Input element channel: four channel samples and the inside flag.
// ---------------------------------------------------------------------------
interface wtr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wtr_pkg::SAMPLE_BITS-1:0] sample_c0;
  logic signed [wtr_pkg::SAMPLE_BITS-1:0] sample_c1;
  logic signed [wtr_pkg::SAMPLE_BITS-1:0] sample_c2;
  logic signed [wtr_pkg::SAMPLE_BITS-1:0] sample_c3;
  logic                                 inside_req;

  modport source (
    output valid, sample_c0, sample_c1, sample_c2, sample_c3, inside_req,
    input  ready
  );
  modport sink (
    input  valid, sample_c0, sample_c1, sample_c2, sample_c3, inside_req,
    output ready
  );
endinterface

/* rtl/core/wtr_out_if.sv */
// ---------------------------------------------------------------------------
// wtr_out_if
// Result channel: four transformed coefficients with tile position.
// ---------------------------------------------------------------------------
interface wtr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wtr_pkg::COEF_BITS-1:0] coef_c0;
  logic signed [wtr_pkg::COEF_BITS-1:0] coef_c1;
  logic signed [wtr_pkg::COEF_BITS-1:0] coef_c2;
  logic signed [wtr_pkg::COEF_BITS-1:0] coef_c3;
  logic [wtr_pkg::DIM_BITS-1:0]         coef_row;
  logic [wtr_pkg::DIM_BITS-1:0]         coef_col;
  logic                                 last_coef;

  modport source (
    output valid, coef_c0, coef_c1, coef_c2, coef_c3, coef_row, coef_col, last_coef,
    input  ready
  );
  modport sink (
    input  valid, coef_c0, coef_c1, coef_c2, coef_c3, coef_row, coef_col, last_coef,
    output ready
  );
endinterface

/* rtl/core/winograd_f2x3_input_tile_transform.sv */
// The sixteenth element loads the column-pass register, which then feeds the output line.
// Each tile gives 16 coefficient beats, one per cycle while out_ready is high; the next tile's
//   elements enter while the current one drains, so tiles can stream back to back.
// The sixteenth element of a tile waits only while the single column-pass register
//   still holds the previous tile, until the output line is empty or takes its last beat.
// Reset (rst_n low, synchronous) clears counters and valid flags; tile data is not reset.
// ---------------------------------------------------------------------------
// winograd_f2x3_input_tile_transform
// Winograd F(2x2,3x3) input tile transform B^T d B over four channel lanes.
// ---------------------------------------------------------------------------
module winograd_f2x3_input_tile_transform (
  input  logic       clk,
  input  logic       rst_n,
  wtr_in_if.sink     in_ch,
  wtr_out_if.source  out_ch
);

  wtr_pkg::wtr_ctl_t                    ctl;
  logic signed [wtr_pkg::SAMPLE_BITS-1:0] smp  [wtr_pkg::LANES];
  logic signed [wtr_pkg::COEF_BITS-1:0]   coef [wtr_pkg::LANES];

  assign smp[0] = in_ch.sample_c0;
  assign smp[1] = in_ch.sample_c1;
  assign smp[2] = in_ch.sample_c2;
  assign smp[3] = in_ch.sample_c3;

  wtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .coef_row  (out_ch.coef_row),
    .coef_col  (out_ch.coef_col),
    .last_coef (out_ch.last_coef),
    .ctl       (ctl)
  );

  for (genvar l = 0; l < wtr_pkg::LANES; l++) begin : g_lane
    wtr_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .sample   (smp[l]),
      .in_image (in_ch.inside_req),
      .coef     (coef[l])
    );
  end

  assign out_ch.coef_c0 = coef[0];
  assign out_ch.coef_c1 = coef[1];
  assign out_ch.coef_c2 = coef[2];
  assign out_ch.coef_c3 = coef[3];

endmodule

/* rtl/core/wtr_lane.sv */
// ---------------------------------------------------------------------------
// wtr_lane
// One channel lane: tile store shift line, column pass register, row pass
// and the output shift line that presents one coefficient per beat.
// ---------------------------------------------------------------------------
module wtr_lane (
  input  logic                                 clk,
  input  wtr_pkg::wtr_ctl_t                    ctl,
  input  logic signed [wtr_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                 in_image,
  output logic signed [wtr_pkg::COEF_BITS-1:0] coef
);

  localparam int N = wtr_pkg::TILE_SIZE;
  localparam int D = wtr_pkg::TILE_DIM;

  logic signed [wtr_pkg::SAMPLE_BITS-1:0] smp;
  logic signed [wtr_pkg::SAMPLE_BITS-1:0] store_r [N];
  logic signed [wtr_pkg::T_BITS-1:0]      d_ext   [N];
  logic signed [wtr_pkg::T_BITS-1:0]      t_r     [N];
  logic signed [wtr_pkg::T_BITS-1:0]      t_nxt   [N];
  logic signed [wtr_pkg::COEF_BITS-1:0]   res_r   [N];
  logic signed [wtr_pkg::COEF_BITS-1:0]   res_nxt [N];

  // padding reads as zero in every lane
  assign smp = in_image ? sample : '0;

  always_ff @(posedge clk) begin
    if (ctl.shift_in) begin
      for (int i = 0; i < N - 1; i++) begin
        store_r[i] <= store_r[i + 1];
      end
      store_r[N - 1] <= smp;
    end
  end

  // on the sixteenth beat elements 0..14 sit in store slots 1..15 and the
  // last element is still on the input
  for (genvar k = 0; k < N; k++) begin : g_elem
    if (k < N - 1) begin : g_st
      assign d_ext[k] = wtr_pkg::T_BITS'(store_r[k + 1]);
    end else begin : g_in
      assign d_ext[k] = wtr_pkg::T_BITS'(smp);
    end
  end

  // column pass: B^T d
  always_comb begin
    for (int c = 0; c < D; c++) begin
      t_nxt[0 * D + c] = d_ext[0 * D + c] - d_ext[2 * D + c];
      t_nxt[1 * D + c] = d_ext[1 * D + c] + d_ext[2 * D + c];
      t_nxt[2 * D + c] = d_ext[2 * D + c] - d_ext[1 * D + c];
      t_nxt[3 * D + c] = d_ext[3 * D + c] - d_ext[1 * D + c];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.t_load) begin
      t_r <= t_nxt;
    end
  end

  // row pass: (B^T d) B
  always_comb begin
    for (int r = 0; r < D; r++) begin
      res_nxt[r * D + 0] = wtr_pkg::COEF_BITS'(t_r[r * D + 0])
                         - wtr_pkg::COEF_BITS'(t_r[r * D + 2]);
      res_nxt[r * D + 1] = wtr_pkg::COEF_BITS'(t_r[r * D + 1])
                         + wtr_pkg::COEF_BITS'(t_r[r * D + 2]);
      res_nxt[r * D + 2] = wtr_pkg::COEF_BITS'(t_r[r * D + 2])
                         - wtr_pkg::COEF_BITS'(t_r[r * D + 1]);
      res_nxt[r * D + 3] = wtr_pkg::COEF_BITS'(t_r[r * D + 3])
                         - wtr_pkg::COEF_BITS'(t_r[r * D + 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.r_load) begin
      res_r <= res_nxt;
    end else if (ctl.r_shift) begin
      for (int i = 0; i < N - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

  assign coef = res_r[0];

endmodule

/* rtl/core/wtr_ctrl.sv */
// ---------------------------------------------------------------------------
// wtr_ctrl
// Element counter, hand-off between the column pass and the output line,
// and the merge side that tags each result beat with row, column and last.
// ---------------------------------------------------------------------------
module wtr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wtr_pkg::DIM_BITS-1:0]  coef_row,
  output logic [wtr_pkg::DIM_BITS-1:0]  coef_col,
  output logic                          last_coef,
  output wtr_pkg::wtr_ctl_t             ctl
);

  wtr_pkg::idx_t cnt_r, cnt_nxt;
  wtr_pkg::idx_t emit_r, emit_nxt;
  logic          t_vld_r, t_vld_nxt;
  logic          out_vld_r, out_vld_nxt;

  logic acc, acc_last, beat, beat_last, res_free, t_mv;

  assign beat      = out_vld_r && out_ready;
  assign beat_last = beat && (emit_r == wtr_pkg::LAST_IDX);
  assign res_free  = !out_vld_r || beat_last;
  assign t_mv      = t_vld_r && res_free;

  // hold the sixteenth element until the column pass register frees up
  assign in_ready  = (cnt_r != wtr_pkg::LAST_IDX) || !t_vld_r || t_mv;
  assign acc       = in_valid && in_ready;
  assign acc_last  = acc && (cnt_r == wtr_pkg::LAST_IDX);

  assign ctl.shift_in = acc;
  assign ctl.t_load   = acc_last;
  assign ctl.r_load   = t_mv;
  assign ctl.r_shift  = beat;

  always_comb begin
    cnt_nxt     = acc ? cnt_r + 1'b1 : cnt_r;
    t_vld_nxt   = acc_last ? 1'b1 : (t_mv ? 1'b0 : t_vld_r);
    out_vld_nxt = t_mv ? 1'b1 : (beat_last ? 1'b0 : out_vld_r);
    emit_nxt    = t_mv ? '0 : (beat ? emit_r + 1'b1 : emit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      emit_r    <= '0;
      t_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      emit_r    <= emit_nxt;
      t_vld_r   <= t_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign coef_row  = emit_r[wtr_pkg::IDX_BITS-1:wtr_pkg::DIM_BITS];
  assign coef_col  = emit_r[wtr_pkg::DIM_BITS-1:0];
  assign last_coef = (emit_r == wtr_pkg::LAST_IDX);

`ifndef SYNTHESIS
  a_t_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (t_vld_r && !t_mv) |=> t_vld_r)
    else $error("column pass result dropped before hand-off");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    t_mv |=> (out_vld_r && emit_r == '0))
    else $error("output line did not restart at coefficient zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    t_mv |-> (!out_vld_r || (beat && emit_r == wtr_pkg::LAST_IDX)))
    else $error("output line reloaded while coefficients remain");

  a_mid_tile: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && emit_r != wtr_pkg::LAST_IDX) |=> out_vld_r)
    else $error("result stream ended before the sixteenth coefficient");
`endif

endmodule

/* test/winograd_f2x3_input_tile_transform_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// winograd_f2x3_input_tile_transform_tb
// Streams 4x4 tiles of four-lane samples, some with padding elements, into
// the tile transform. A local B^T d B predictor queues the sixteen expected
// coefficient beats of each tile. A sink process compares every coefficient
// beat as it arrives, under random gaps, stalls and one long output hold-off.
// ---------------------------------------------------------------------------
module winograd_f2x3_input_tile_transform_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLDOFF_CYCLES = 400;

  localparam logic [wtr_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
    {1'b0, {(wtr_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic [wtr_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
    {1'b1, {(wtr_pkg::SAMPLE_BITS-1){1'b0}}};

  typedef logic [wtr_pkg::LANES-1:0][wtr_pkg::SAMPLE_BITS-1:0] element_t;

  typedef struct packed {
    logic [wtr_pkg::LANES-1:0][wtr_pkg::COEF_BITS-1:0] lane;
    logic [wtr_pkg::DIM_BITS-1:0]                      row;
    logic [wtr_pkg::DIM_BITS-1:0]                      col;
    logic                                              last;
  } coef_beat_t;

  logic clk;
  logic rst_n;

  wtr_in_if  in_if();
  wtr_out_if out_if();

  winograd_f2x3_input_tile_transform dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor state: the tile gathered so far and its fill level
  logic signed [wtr_pkg::SAMPLE_BITS-1:0] tile_elem [wtr_pkg::TILE_SIZE][wtr_pkg::LANES];
  int unsigned elem_count = 0;

  coef_beat_t  expected_coefs[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_en = 1'b1;
  int unsigned rx_hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned pick;
    if (!idle_en) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [wtr_pkg::SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return wtr_pkg::SAMPLE_BITS'($urandom_range(0, 16))
                      - wtr_pkg::SAMPLE_BITS'(8);
      default: return wtr_pkg::SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic string fmt_beat(coef_beat_t b);
    return $sformatf("c0 %0d c1 %0d c2 %0d c3 %0d row %0d col %0d last %0b",
                     $signed(b.lane[0]), $signed(b.lane[1]), $signed(b.lane[2]),
                     $signed(b.lane[3]), b.row, b.col, b.last);
  endfunction

  // B^T d B per lane, then queue the sixteen beats in row-major order
  function automatic void predict_tile_transform();
    int         d [wtr_pkg::TILE_DIM][wtr_pkg::TILE_DIM];
    int         t [wtr_pkg::TILE_DIM][wtr_pkg::TILE_DIM];
    coef_beat_t beats [wtr_pkg::TILE_SIZE];
    for (int ln = 0; ln < wtr_pkg::LANES; ln++) begin
      for (int k = 0; k < wtr_pkg::TILE_SIZE; k++)
        d[k / wtr_pkg::TILE_DIM][k % wtr_pkg::TILE_DIM] = int'(tile_elem[k][ln]);
      // column pass: B^T down each column
      for (int c = 0; c < wtr_pkg::TILE_DIM; c++) begin
        t[0][c] = d[0][c] - d[2][c];
        t[1][c] = d[1][c] + d[2][c];
        t[2][c] = d[2][c] - d[1][c];
        t[3][c] = d[3][c] - d[1][c];
      end
      // row pass: same combination across each row
      for (int r = 0; r < wtr_pkg::TILE_DIM; r++) begin
        beats[r * wtr_pkg::TILE_DIM + 0].lane[ln] = wtr_pkg::COEF_BITS'(t[r][0] - t[r][2]);
        beats[r * wtr_pkg::TILE_DIM + 1].lane[ln] = wtr_pkg::COEF_BITS'(t[r][1] + t[r][2]);
        beats[r * wtr_pkg::TILE_DIM + 2].lane[ln] = wtr_pkg::COEF_BITS'(t[r][2] - t[r][1]);
        beats[r * wtr_pkg::TILE_DIM + 3].lane[ln] = wtr_pkg::COEF_BITS'(t[r][3] - t[r][1]);
      end
    end
    for (int k = 0; k < wtr_pkg::TILE_SIZE; k++) begin
      beats[k].row  = wtr_pkg::DIM_BITS'(k / wtr_pkg::TILE_DIM);
      beats[k].col  = wtr_pkg::DIM_BITS'(k % wtr_pkg::TILE_DIM);
      beats[k].last = (k == wtr_pkg::TILE_SIZE - 1);
      expected_coefs.push_back(beats[k]);
    end
  endfunction

  function automatic void record_element(element_t e, bit in_image);
    // padding lands as zero in every lane
    for (int ln = 0; ln < wtr_pkg::LANES; ln++)
      tile_elem[elem_count][ln] = in_image ? e[ln] : '0;
    if (elem_count == wtr_pkg::TILE_SIZE - 1) begin
      elem_count = 0;
      predict_tile_transform();
    end else begin
      elem_count++;
    end
  endfunction

  function automatic void check_coef_beat();
    coef_beat_t got;
    coef_beat_t want;
    bit         bad;
    got.lane[0] = out_if.coef_c0;
    got.lane[1] = out_if.coef_c1;
    got.lane[2] = out_if.coef_c2;
    got.lane[3] = out_if.coef_c3;
    got.row     = out_if.coef_row;
    got.col     = out_if.coef_col;
    got.last    = out_if.last_coef;
    if (expected_coefs.size() == 0) begin
      note_failure({"unexpected coefficient beat: ", fmt_beat(got)});
      return;
    end
    want = expected_coefs.pop_front();
    bad = (got.row !== want.row) || (got.col !== want.col) || (got.last !== want.last);
    for (int ln = 0; ln < wtr_pkg::LANES; ln++)
      if (got.lane[ln] !== want.lane[ln]) bad = 1'b1;
    if (bad)
      note_failure({"coefficient mismatch: exp ", fmt_beat(want), " got ", fmt_beat(got)});
  endfunction

  // offer one element, hold it until the beat, then feed the predictor
  task automatic send_element(input element_t e, input bit in_image);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.sample_c0  <= e[0];
    in_if.sample_c1  <= e[1];
    in_if.sample_c2  <= e[2];
    in_if.sample_c3  <= e[3];
    in_if.inside_req <= in_image;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    record_element(e, in_image);
  endtask

  task automatic wait_coefs_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_coefs.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_tile();
    element_t    e;
    bit          in_image;
    int unsigned pad_style;
    pad_style = $urandom_range(0, 9);
    for (int k = 0; k < wtr_pkg::TILE_SIZE; k++) begin
      for (int ln = 0; ln < wtr_pkg::LANES; ln++) e[ln] = rand_sample();
      case (pad_style)
        0:       in_image = 1'b0;                                   // fully off-image
        1:       in_image = (k / wtr_pkg::TILE_DIM != 0)
                            && (k % wtr_pkg::TILE_DIM != 0);        // top-left corner
        2:       in_image = (k / wtr_pkg::TILE_DIM < 2);            // bottom edge
        default: in_image = ($urandom_range(0, 7) != 0);
      endcase
      send_element(e, in_image);
    end
  endtask

  // full-scale checkerboard and half-plane tiles, a walking one, loud padding
  task automatic test_directed_extremes();
    element_t e;
    int       r;
    int       c;
    for (int k = 0; k < wtr_pkg::TILE_SIZE; k++) begin
      r = k / wtr_pkg::TILE_DIM;
      c = k % wtr_pkg::TILE_DIM;
      e[0] = ((r + c) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
      e[1] = (r < 2) ? SAMPLE_MAX : SAMPLE_MIN;
      e[2] = (c < 2) ? SAMPLE_MIN : SAMPLE_MAX;
      e[3] = wtr_pkg::SAMPLE_BITS'(1) << k;
      send_element(e, !(k == 5 || k == 10));
    end
  endtask

  task automatic test_random_tiles();
    repeat (10) send_random_tile();
  endtask

  // hold the output off long enough that the block stops taking elements
  task automatic test_output_holdoff();
    rx_hold_left = HOLDOFF_CYCLES;
    repeat (3) send_random_tile();
  endtask

  task automatic test_drain_pause();
    send_random_tile();
    wait_coefs_drained();
    repeat (2) send_random_tile();
    wait_coefs_drained();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (3) send_random_tile();
    wait_coefs_drained();
    idle_en = 1'b1;
  endtask

  // coefficient sink: check each beat, then decide ready for the next cycle
  initial begin : coef_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_coef_beat();
      if (rx_hold_left > 0) begin
        out_if.ready <= 1'b0;
        rx_hold_left--;
      end else if (!rst_n || stall_left > 0) begin
        out_if.ready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** winograd_f2x3_input_tile_transform: FAILED **");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.sample_c0  <= '0;
    in_if.sample_c1  <= '0;
    in_if.sample_c2  <= '0;
    in_if.sample_c3  <= '0;
    in_if.inside_req <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_random_tiles();
    test_output_holdoff();
    test_drain_pause();
    test_back_to_back();

    wait_coefs_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** winograd_f2x3_input_tile_transform: PASSED **");
    end else begin
      $display("** winograd_f2x3_input_tile_transform: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/wtr_pkg.sv
rtl/core/wtr_in_if.sv
rtl/core/wtr_out_if.sv
rtl/core/wtr_lane.sv
rtl/core/wtr_ctrl.sv
rtl/core/winograd_f2x3_input_tile_transform.sv
test/winograd_f2x3_input_tile_transform_tb.sv
